### rtl/dttfp_pkg.sv
// shared types, codes and defaults for the decimal text to fixed point converter
package dttfp_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned IntBitsDef       = 32;
  localparam int unsigned FracBitsDef      = 32;
  localparam int unsigned MaxFracDigitsDef = 9;

  // width of the result magnitude ports
  localparam int unsigned OutW = 32;

  // character codes
  localparam logic [7:0] CharTab      = 8'd9;
  localparam logic [7:0] CharCr       = 8'd13;
  localparam logic [7:0] CharSpace    = 8'd32;
  localparam logic [7:0] CharMinus    = 8'h2d;
  localparam logic [7:0] CharPlus     = 8'h2b;
  localparam logic [7:0] CharPoint    = 8'h2e;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharNine     = 8'h39;
  localparam logic [7:0] CaseBit      = 8'h20;
  localparam logic [7:0] CharLowerA   = 8'h61;
  localparam logic [7:0] CharLowerF   = 8'h66;
  localparam logic [7:0] CharLowerI   = 8'h69;
  localparam logic [7:0] CharLowerN   = 8'h6e;

  // parse phase
  typedef enum logic [2:0] {
    PH_DONE,
    PH_SPACE,
    PH_SIGNED,
    PH_INF,
    PH_NAN,
    PH_INT,
    PH_FRAC
  } phase_e;

  // kind of value in a result beat
  typedef enum logic [1:0] {
    KIND_FINITE,
    KIND_INF,
    KIND_NAN
  } kind_e;

  // one result beat
  typedef struct packed {
    kind_e             kind;
    logic              negative;
    logic [OutW-1:0]   int_part;
    logic [OutW-1:0]   frac_part;
    logic              saturated;
  } result_t;

endpackage

### rtl/decimal_text_to_fixed_point_top.sv
// Decimal text to fixed point converter, streaming one character per beat.
//
// Input channel: char_code_i with first_char_i, handshaked by in_valid_i and
// in_ready_o. A beat with first_char_i high restarts the parse. Leading
// whitespace and one sign are taken, then "inf", "nan" or decimal digits with
// at most one point. The first character that cannot belong to the number
// (NUL included) closes it and produces one result beat; further characters
// are dropped until the next start beat.
// Output channel: value_kind_o, is_negative_o, integer_part_o (saturated),
// fraction_part_o (unsigned Q0.32) and saturated_o, under out_valid_o and
// out_ready_i.
// A closing character is captured in the input register, and its result then
// in the result register. Throughput: one character every cycle while results
// are taken, set by the combinational parse step between the two registers.
// When the receiver stalls, a held result keeps the input register waiting
// and in_ready_o drops once that register is also full.
// Reset clears the parse, so characters are ignored until a start beat.
module decimal_text_to_fixed_point_top #(
  parameter int unsigned INT_BITS        = dttfp_pkg::IntBitsDef,
  parameter int unsigned FRAC_BITS       = dttfp_pkg::FracBitsDef,
  parameter int unsigned MAX_FRAC_DIGITS = dttfp_pkg::MaxFracDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        first_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  value_kind_o,
  output logic        is_negative_o,
  output logic [31:0] integer_part_o,
  output logic [31:0] fraction_part_o,
  output logic        saturated_o
);

  logic               in_valid_q, in_valid_d;
  logic [7:0]         char_q;
  logic               first_q;
  logic               out_valid_q, out_valid_d;
  dttfp_pkg::result_t result_q;
  dttfp_pkg::result_t core_result;
  logic               core_valid;
  logic               step;
  logic               in_fire;

  // handshake: step the parser when the result register can take a beat
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign in_fire     = in_valid_i && in_ready_o;
  assign in_valid_d  = in_fire || (in_valid_q && !step);
  assign out_valid_d = (step && core_valid) || (out_valid_q && !out_ready_i);

  dttfp_parse #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_i      (char_q),
    .first_i     (first_q),
    .res_valid_o (core_valid),
    .result_o    (core_result)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input beat register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q  <= char_code_i;
      first_q <= first_char_i;
    end
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (step && core_valid) begin
      result_q <= core_result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign value_kind_o    = result_q.kind;
  assign is_negative_o   = result_q.negative;
  assign integer_part_o  = result_q.int_part;
  assign fraction_part_o = result_q.frac_part;
  assign saturated_o     = result_q.saturated;

endmodule

### rtl/dttfp_parse.sv
// parse state machine and digit accumulators, one character per step
module dttfp_parse #(
  parameter int unsigned INT_BITS        = dttfp_pkg::IntBitsDef,
  parameter int unsigned FRAC_BITS       = dttfp_pkg::FracBitsDef,
  parameter int unsigned MAX_FRAC_DIGITS = dttfp_pkg::MaxFracDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          char_i,
  input  logic                first_i,
  output logic                res_valid_o,
  output dttfp_pkg::result_t  result_o
);

  // rounded weights of fraction digits, 2^FRAC_BITS / 10^k
  localparam logic [63:0] FracOne = 64'd1 << FRAC_BITS;
  localparam logic [63:0] W1 = (FracOne + 64'd5) / 64'd10;
  localparam logic [63:0] W2 = (FracOne + 64'd50) / 64'd100;
  localparam logic [63:0] W3 = (FracOne + 64'd500) / 64'd1000;
  localparam logic [63:0] W4 = (FracOne + 64'd5000) / 64'd10000;
  localparam logic [63:0] W5 = (FracOne + 64'd50000) / 64'd100000;
  localparam logic [63:0] W6 = (FracOne + 64'd500000) / 64'd1000000;
  localparam logic [63:0] W7 = (FracOne + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] W8 = (FracOne + 64'd50000000) / 64'd100000000;
  localparam logic [63:0] W9 = (FracOne + 64'd500000000) / 64'd1000000000;
  localparam logic [3:0]  MaxDigits = 4'(MAX_FRAC_DIGITS);

  dttfp_pkg::phase_e     phase_q, phase_d;
  logic [1:0]            letters_q, letters_d;
  logic                  neg_q, neg_d;
  logic [INT_BITS-1:0]   int_q, int_d;
  logic [FRAC_BITS-1:0]  frac_q, frac_d;
  logic [3:0]            cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;

  // state as seen by this character, a start beat restarts everything
  dttfp_pkg::phase_e     eff_phase;
  logic [1:0]            eff_letters;
  logic                  eff_neg;
  logic [INT_BITS-1:0]   eff_int;
  logic [FRAC_BITS-1:0]  eff_frac;
  logic [3:0]            eff_cnt;
  logic                  eff_ovf;

  logic [7:0]            lower;
  logic                  is_ws, is_minus, is_plus, is_digit, is_point, is_i, is_n;
  logic [3:0]            digit;
  logic [7:0]            want;
  logic                  word_hit, last_letter;

  logic [INT_BITS+3:0]   int_sum;
  logic [FRAC_BITS-1:0]  frac_weight;
  logic [FRAC_BITS+4:0]  frac_sum;

  always_comb begin
    if (first_i) begin
      eff_phase   = dttfp_pkg::PH_SPACE;
      eff_letters = '0;
      eff_neg     = 1'b0;
      eff_int     = '0;
      eff_frac    = '0;
      eff_cnt     = '0;
      eff_ovf     = 1'b0;
    end else begin
      eff_phase   = phase_q;
      eff_letters = letters_q;
      eff_neg     = neg_q;
      eff_int     = int_q;
      eff_frac    = frac_q;
      eff_cnt     = cnt_q;
      eff_ovf     = ovf_q;
    end
  end

  // character classes
  assign lower    = char_i | dttfp_pkg::CaseBit;
  assign is_ws    = ((char_i >= dttfp_pkg::CharTab) && (char_i <= dttfp_pkg::CharCr)) ||
                    (char_i == dttfp_pkg::CharSpace);
  assign is_minus = (char_i == dttfp_pkg::CharMinus);
  assign is_plus  = (char_i == dttfp_pkg::CharPlus);
  assign is_point = (char_i == dttfp_pkg::CharPoint);
  assign is_digit = (char_i >= dttfp_pkg::CharZero) && (char_i <= dttfp_pkg::CharNine);
  assign digit    = 4'(char_i - dttfp_pkg::CharZero);
  assign is_i     = (lower == dttfp_pkg::CharLowerI);
  assign is_n     = (lower == dttfp_pkg::CharLowerN);

  // next letter expected in the inf or nan word
  always_comb begin
    want = dttfp_pkg::CharLowerI;
    if (eff_phase == dttfp_pkg::PH_NAN) begin
      unique case (eff_letters)
        2'd0:    want = dttfp_pkg::CharLowerN;
        2'd1:    want = dttfp_pkg::CharLowerA;
        default: want = dttfp_pkg::CharLowerN;
      endcase
    end else begin
      unique case (eff_letters)
        2'd0:    want = dttfp_pkg::CharLowerI;
        2'd1:    want = dttfp_pkg::CharLowerN;
        default: want = dttfp_pkg::CharLowerF;
      endcase
    end
  end

  assign word_hit    = (eff_letters != 2'd3) && (lower == want);
  assign last_letter = (eff_letters == 2'd2);

  // integer digit: times ten plus digit
  assign int_sum = (INT_BITS+4)'({eff_int, 3'b000}) + (INT_BITS+4)'({eff_int, 1'b0}) +
                   (INT_BITS+4)'(digit);

  // weight of the next fraction digit
  always_comb begin
    unique case (eff_cnt)
      4'd0:    frac_weight = W1[FRAC_BITS-1:0];
      4'd1:    frac_weight = W2[FRAC_BITS-1:0];
      4'd2:    frac_weight = W3[FRAC_BITS-1:0];
      4'd3:    frac_weight = W4[FRAC_BITS-1:0];
      4'd4:    frac_weight = W5[FRAC_BITS-1:0];
      4'd5:    frac_weight = W6[FRAC_BITS-1:0];
      4'd6:    frac_weight = W7[FRAC_BITS-1:0];
      4'd7:    frac_weight = W8[FRAC_BITS-1:0];
      4'd8:    frac_weight = W9[FRAC_BITS-1:0];
      default: frac_weight = '0;
    endcase
  end

  assign frac_sum = {5'b00000, eff_frac} +
                    {1'b0, (FRAC_BITS+4)'(frac_weight) * (FRAC_BITS+4)'(digit)};

  // next phase
  always_comb begin
    dttfp_pkg::phase_e num_next, start_next;
    if (is_digit) begin
      num_next = (eff_phase == dttfp_pkg::PH_FRAC) ? dttfp_pkg::PH_FRAC : dttfp_pkg::PH_INT;
    end else if (is_point && (eff_phase != dttfp_pkg::PH_FRAC)) begin
      num_next = dttfp_pkg::PH_FRAC;
    end else begin
      num_next = dttfp_pkg::PH_DONE;
    end
    if (is_i) begin
      start_next = dttfp_pkg::PH_INF;
    end else if (is_n) begin
      start_next = dttfp_pkg::PH_NAN;
    end else begin
      start_next = num_next;
    end
    phase_d = phase_q;
    if (step_i) begin
      unique case (eff_phase)
        dttfp_pkg::PH_SPACE: begin
          if (is_ws) begin
            phase_d = dttfp_pkg::PH_SPACE;
          end else if (is_minus || is_plus) begin
            phase_d = dttfp_pkg::PH_SIGNED;
          end else begin
            phase_d = start_next;
          end
        end
        dttfp_pkg::PH_SIGNED: phase_d = start_next;
        dttfp_pkg::PH_INF, dttfp_pkg::PH_NAN: begin
          if (word_hit && !last_letter) begin
            phase_d = eff_phase;
          end else begin
            phase_d = dttfp_pkg::PH_DONE;
          end
        end
        dttfp_pkg::PH_INT, dttfp_pkg::PH_FRAC: phase_d = num_next;
        default: phase_d = dttfp_pkg::PH_DONE;
      endcase
    end
  end

  // accumulators and result
  always_comb begin
    logic in_number, at_start;
    in_number = (eff_phase == dttfp_pkg::PH_SPACE) || (eff_phase == dttfp_pkg::PH_SIGNED) ||
                (eff_phase == dttfp_pkg::PH_INT) || (eff_phase == dttfp_pkg::PH_FRAC);
    at_start  = (eff_phase == dttfp_pkg::PH_SPACE) || (eff_phase == dttfp_pkg::PH_SIGNED);

    letters_d = letters_q;
    neg_d     = neg_q;
    int_d     = int_q;
    frac_d    = frac_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    if (step_i) begin
      letters_d = eff_letters;
      neg_d     = eff_neg;
      int_d     = eff_int;
      frac_d    = eff_frac;
      cnt_d     = eff_cnt;
      ovf_d     = eff_ovf;
      if ((eff_phase == dttfp_pkg::PH_SPACE) && is_minus) begin
        neg_d = 1'b1;
      end
      if (at_start && (is_i || is_n)) begin
        letters_d = 2'd1;
      end
      if (((eff_phase == dttfp_pkg::PH_INF) || (eff_phase == dttfp_pkg::PH_NAN)) && word_hit) begin
        letters_d = 2'(eff_letters + 2'd1);
      end
      if (in_number && is_digit) begin
        if (eff_phase == dttfp_pkg::PH_FRAC) begin
          if (eff_cnt < MaxDigits) begin
            cnt_d  = 4'(eff_cnt + 4'd1);
            frac_d = (|frac_sum[FRAC_BITS+4:FRAC_BITS]) ? '1 : frac_sum[FRAC_BITS-1:0];
          end
        end else if (|int_sum[INT_BITS+3:INT_BITS]) begin
          int_d = '1;
          ovf_d = 1'b1;
        end else begin
          int_d = int_sum[INT_BITS-1:0];
        end
      end
    end

    res_valid_o = step_i && (eff_phase != dttfp_pkg::PH_DONE) &&
                  (phase_d == dttfp_pkg::PH_DONE);
    result_o.kind       = dttfp_pkg::KIND_FINITE;
    result_o.negative   = eff_neg;
    result_o.int_part   = '0;
    result_o.int_part[INT_BITS-1:0] = eff_int;
    result_o.frac_part  = '0;
    result_o.frac_part[dttfp_pkg::OutW-1 -: FRAC_BITS] = '0;
    result_o.frac_part[FRAC_BITS-1:0] = eff_frac;
    result_o.saturated  = eff_ovf;
    if (word_hit && (eff_phase == dttfp_pkg::PH_INF)) begin
      result_o.kind      = dttfp_pkg::KIND_INF;
      result_o.int_part  = '0;
      result_o.frac_part = '0;
      result_o.saturated = 1'b0;
    end else if (word_hit && (eff_phase == dttfp_pkg::PH_NAN)) begin
      result_o.kind      = dttfp_pkg::KIND_NAN;
      result_o.negative  = 1'b0;
      result_o.int_part  = '0;
      result_o.frac_part = '0;
      result_o.saturated = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= dttfp_pkg::PH_DONE;
      letters_q <= '0;
      neg_q     <= 1'b0;
      int_q     <= '0;
      frac_q    <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      letters_q <= letters_d;
      neg_q     <= neg_d;
      int_q     <= int_d;
      frac_q    <= frac_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

### dv/decimal_text_to_fixed_point_top_tb.sv
// self-checking testbench for the decimal text to fixed point converter
module decimal_text_to_fixed_point_top_tb;

  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned CharsPerPhase = 300;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned NumPhases     = 4;
  localparam logic [63:0] IntMax        = (64'd1 << dttfp_pkg::IntBitsDef) - 64'd1;
  localparam logic [63:0] FracMax       = (64'd1 << dttfp_pkg::FracBitsDef) - 64'd1;

  // sender idle and receiver stall odds per phase, in percent
  localparam int unsigned IdlePct  [NumPhases] = '{0, 46, 0, 20};
  localparam int unsigned StallPct [NumPhases] = '{0, 0, 46, 20};

  typedef logic [7:0] text_t[$];

  // tracks the parse of the text stream and holds the numbers still due
  class number_scoreboard;
    dttfp_pkg::phase_e  phase;
    logic [1:0]         letters;
    bit                 negative;
    logic [31:0]        int_acc;
    logic [31:0]        frac_acc;
    int unsigned        frac_count;
    bit                 clamped;
    dttfp_pkg::result_t pending_numbers[$];
    int unsigned        chars_seen;
    int unsigned        parsed_chars;
    int unsigned        failures;
    int unsigned        kind_counts[3];
    int unsigned        clamped_seen;

    function new();
      clear_parse();
      phase = dttfp_pkg::PH_DONE;
    endfunction

    function void clear_parse();
      letters    = '0;
      negative   = 1'b0;
      int_acc    = '0;
      frac_acc   = '0;
      frac_count = 0;
      clamped    = 1'b0;
    endfunction

    // rounded weight of the k-th fraction digit, 2^FRAC_BITS / 10^k
    function logic [63:0] digit_weight(int unsigned k);
      logic [63:0] p;
      p = 64'd1;
      repeat (k) p = p * 64'd10;
      return ((64'd1 << dttfp_pkg::FracBitsDef) + p / 64'd2) / p;
    endfunction

    function void push_number(dttfp_pkg::kind_e k, bit neg, logic [31:0] ip,
                              logic [31:0] fp, bit sat);
      dttfp_pkg::result_t r;
      r.kind      = k;
      r.negative  = neg;
      r.int_part  = ip;
      r.frac_part = fp;
      r.saturated = sat;
      pending_numbers.push_back(r);
      phase = dttfp_pkg::PH_DONE;
    endfunction

    // digits, the single point, or the character that closes a finite number
    function void take_number_char(logic [7:0] c);
      logic [63:0] acc;
      if (c >= dttfp_pkg::CharZero && c <= dttfp_pkg::CharNine) begin
        if (phase == dttfp_pkg::PH_FRAC) begin
          if (frac_count < dttfp_pkg::MaxFracDigitsDef) begin
            frac_count++;
            acc = 64'(frac_acc) + 64'(c - dttfp_pkg::CharZero) * digit_weight(frac_count);
            frac_acc = (acc > FracMax) ? FracMax[31:0] : acc[31:0];
          end
        end else begin
          acc = 64'(int_acc) * 64'd10 + 64'(c - dttfp_pkg::CharZero);
          if (acc > IntMax) begin
            acc = IntMax;
            clamped = 1'b1;
          end
          int_acc = acc[31:0];
          phase = dttfp_pkg::PH_INT;
        end
      end else if (c == dttfp_pkg::CharPoint && phase != dttfp_pkg::PH_FRAC) begin
        phase = dttfp_pkg::PH_FRAC;
      end else begin
        push_number(dttfp_pkg::KIND_FINITE, negative, int_acc, frac_acc, clamped);
      end
    endfunction

    // first character after whitespace and sign: a word or a number
    function void take_lead_char(logic [7:0] c);
      logic [7:0] l;
      l = c | dttfp_pkg::CaseBit;
      if (l == dttfp_pkg::CharLowerI) begin
        phase = dttfp_pkg::PH_INF;
        letters = 2'd1;
      end else if (l == dttfp_pkg::CharLowerN) begin
        phase = dttfp_pkg::PH_NAN;
        letters = 2'd1;
      end else begin
        take_number_char(c);
      end
    endfunction

    function logic [7:0] word_letter(dttfp_pkg::kind_e k, logic [1:0] idx);
      if (k == dttfp_pkg::KIND_INF) begin
        if (idx == 2'd0) return dttfp_pkg::CharLowerI;
        if (idx == 2'd1) return dttfp_pkg::CharLowerN;
        return dttfp_pkg::CharLowerF;
      end
      return (idx == 2'd1) ? dttfp_pkg::CharLowerA : dttfp_pkg::CharLowerN;
    endfunction

    // letters of inf or nan, a mismatch closes a finite zero
    function void take_letter(logic [7:0] c, dttfp_pkg::kind_e k);
      if (letters < 2'd3 && (c | dttfp_pkg::CaseBit) == word_letter(k, letters)) begin
        letters++;
        if (letters == 2'd3)
          push_number(k, (k == dttfp_pkg::KIND_INF) ? negative : 1'b0, '0, '0, 1'b0);
      end else begin
        push_number(dttfp_pkg::KIND_FINITE, negative, int_acc, frac_acc, clamped);
      end
    endfunction

    // predicts the effect of one accepted input beat
    function void parse_char(logic [7:0] c, bit first);
      chars_seen++;
      if (first) begin
        clear_parse();
        phase = dttfp_pkg::PH_SPACE;
      end
      if (phase != dttfp_pkg::PH_DONE) parsed_chars++;
      case (phase)
        dttfp_pkg::PH_SPACE: begin
          if ((c >= dttfp_pkg::CharTab && c <= dttfp_pkg::CharCr) ||
              c == dttfp_pkg::CharSpace) begin
            // leading whitespace skipped
          end else if (c == dttfp_pkg::CharMinus) begin
            negative = 1'b1;
            phase = dttfp_pkg::PH_SIGNED;
          end else if (c == dttfp_pkg::CharPlus) begin
            phase = dttfp_pkg::PH_SIGNED;
          end else begin
            take_lead_char(c);
          end
        end
        dttfp_pkg::PH_SIGNED: take_lead_char(c);
        dttfp_pkg::PH_INF: take_letter(c, dttfp_pkg::KIND_INF);
        dttfp_pkg::PH_NAN: take_letter(c, dttfp_pkg::KIND_NAN);
        dttfp_pkg::PH_INT, dttfp_pkg::PH_FRAC: take_number_char(c);
        default: ;
      endcase
    endfunction

    function void report(string what, bit have_want, dttfp_pkg::result_t want,
                         dttfp_pkg::result_t got);
      failures++;
      if (failures <= MaxReports) begin
        if (have_want)
          $display("%s: kind %0d/%0d neg %0d/%0d int %08h/%08h frac %08h/%08h sat %0d/%0d",
                   what, want.kind, got.kind, want.negative, got.negative, want.int_part,
                   got.int_part, want.frac_part, got.frac_part, want.saturated, got.saturated);
        else
          $display("%s: kind %0d neg %0d int %08h frac %08h sat %0d", what, got.kind,
                   got.negative, got.int_part, got.frac_part, got.saturated);
      end
    endfunction

    // compares a result beat with the oldest number due
    function void check_result(dttfp_pkg::result_t got);
      dttfp_pkg::result_t want;
      if (pending_numbers.size() == 0) begin
        report("result with nothing due", 1'b0, want, got);
        return;
      end
      want = pending_numbers.pop_front();
      kind_counts[want.kind]++;
      if (want.saturated) clamped_seen++;
      if (got.kind !== want.kind || got.negative !== want.negative ||
          got.int_part !== want.int_part || got.frac_part !== want.frac_part ||
          got.saturated !== want.saturated)
        report("mismatch (expected/actual)", 1'b1, want, got);
    endfunction

    function void close();
      if (pending_numbers.size() != 0) begin
        failures += pending_numbers.size();
        $display("%0d expected results never arrived", pending_numbers.size());
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i  = 8'h00;
  logic        first_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  value_kind_o;
  logic        is_negative_o;
  logic [31:0] integer_part_o;
  logic [31:0] fraction_part_o;
  logic        saturated_o;

  number_scoreboard sb;
  int unsigned      sender_idle_pct    = 0;
  int unsigned      receiver_stall_pct = 0;
  int unsigned      quiet_cycles       = 0;

  decimal_text_to_fixed_point_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .char_code_i,
    .first_char_i,
    .out_valid_o,
    .out_ready_i,
    .value_kind_o,
    .is_negative_o,
    .integer_part_o,
    .fraction_part_o,
    .saturated_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check each accepted beat, then decide the next ready
  always @(posedge clk_i) begin
    dttfp_pkg::result_t beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beat.kind      = dttfp_pkg::kind_e'(value_kind_o);
      beat.negative  = is_negative_o;
      beat.int_part  = integer_part_o;
      beat.frac_part = fraction_part_o;
      beat.saturated = saturated_o;
      sb.check_result(beat);
    end
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("no beat moved for %0d cycles", QuietLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one character beat, with random idle cycles ahead of it
  task automatic send_beat(logic [7:0] c, bit first);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_code_i  <= c;
    first_char_i <= first;
    do @(posedge clk_i); while (!in_ready_o);
    sb.parse_char(c, first);
  endtask

  task automatic send_text(text_t t, bit with_start);
    foreach (t[i]) send_beat(t[i], with_start && i == 0);
  endtask

  // hold the sender until every due number has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_numbers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic text_t text_of(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  // number or word text with random content, and a random closing character after a numeral
  function automatic text_t make_number();
    text_t       t;
    logic [7:0]  word [3];
    int unsigned sel;
    int unsigned n;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      sel = $urandom_range(5);
      t.push_back((sel == 5) ? dttfp_pkg::CharSpace : dttfp_pkg::CharTab + 8'(sel));
    end
    sel = $urandom_range(3);
    if (sel == 0) t.push_back(dttfp_pkg::CharMinus);
    else if (sel == 1) t.push_back(dttfp_pkg::CharPlus);
    // inf or nan in mixed case, sometimes broken
    sel = $urandom_range(9);
    if (sel < 2) begin
      if (sel == 0)
        word = '{dttfp_pkg::CharLowerI, dttfp_pkg::CharLowerN, dttfp_pkg::CharLowerF};
      else
        word = '{dttfp_pkg::CharLowerN, dttfp_pkg::CharLowerA, dttfp_pkg::CharLowerN};
      if ($urandom_range(3) == 0) word[$urandom_range(2)] = 8'($urandom_range(8'h41, 8'h7a));
      foreach (word[i])
        t.push_back($urandom_range(1) ? (word[i] & ~dttfp_pkg::CaseBit) : word[i]);
      return t;
    end
    // integer digits, long ones now and then to reach the clamp
    sel = $urandom_range(9);
    n = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(10, 12) : $urandom_range(1, 6);
    repeat (n) t.push_back(dttfp_pkg::CharZero + 8'($urandom_range(9)));
    if ($urandom_range(2) != 0) begin
      t.push_back(dttfp_pkg::CharPoint);
      n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
      repeat (n) t.push_back(dttfp_pkg::CharZero + 8'($urandom_range(9)));
    end
    case ($urandom_range(7))
      0, 1, 2: t.push_back(8'h00);
      3:       t.push_back(dttfp_pkg::CharSpace);
      4:       t.push_back(dttfp_pkg::CharPoint);
      5:       t.push_back(8'($urandom_range(128, 255)));
      default: t.push_back(8'($urandom_range(0, 127)));
    endcase
    return t;
  endfunction

  // stimulus
  initial begin
    text_t       t;
    int unsigned goal;
    int unsigned sel;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stray beat before any start, words, broken word, second point,
    // double sign, clamp with excess fraction digits, top byte code as closer
    send_text(text_of("Z"), 1'b0);
    send_text(text_of("iNf"), 1'b1);
    send_text(text_of("nAN"), 1'b1);
    send_text(text_of("+nx"), 1'b1);
    send_text(text_of(".."), 1'b1);
    send_text(text_of("-+"), 1'b1);
    t = text_of("\t-4294967296.1234567891");
    t.push_back(8'h00);
    send_text(t, 1'b1);
    t = text_of("\v7");
    t.push_back(8'hff);
    send_text(t, 1'b1);
    settle();

    // random phases under different idle and stall odds
    for (int p = 0; p < NumPhases; p++) begin
      sender_idle_pct    = IdlePct[p];
      receiver_stall_pct = StallPct[p];
      goal = sb.chars_seen + CharsPerPhase;
      while (sb.chars_seen < goal) begin
        sel = $urandom_range(19);
        if (sel < 2) begin
          // noise with scattered start flags
          repeat ($urandom_range(1, 8)) send_beat(8'($urandom()), $urandom_range(3) == 0);
        end else begin
          t = make_number();
          // now and then the closing character is left off
          if (sel == 2 && t.size() > 1) void'(t.pop_back());
          send_text(t, 1'b1);
          if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_beat(8'($urandom()), 1'b0);
        end
      end
      settle();
    end

    sb.close();
    $display("sent %0d characters, %0d of them inside a parse, over %0d idle/stall phases",
             sb.chars_seen, sb.parsed_chars, NumPhases);
    $display("numbers checked: %0d finite, %0d infinity, %0d nan, %0d clamped",
             sb.kind_counts[dttfp_pkg::KIND_FINITE], sb.kind_counts[dttfp_pkg::KIND_INF],
             sb.kind_counts[dttfp_pkg::KIND_NAN], sb.clamped_seen);
    if (sb.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
